>>> src/lei_pkg.sv
// Shared types, codes and saturation helpers for the Lorenz Euler integrator.
package lei_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_SIGMA   = 3'd0;
   localparam logic [2:0] REG_RHO     = 3'd1;
   localparam logic [2:0] REG_BETA    = 3'd2;
   localparam logic [2:0] REG_DT      = 3'd3;
   localparam logic [2:0] REG_START_X = 3'd4;
   localparam logic [2:0] REG_START_Y = 3'd5;
   localparam logic [2:0] REG_START_Z = 3'd6;

   localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_FIN
   } state_type;

   // One multiply per step but the drain step; every step after the first retires the previous product.
   typedef enum logic [2:0] {
      STEP_SIGMA,
      STEP_X_RZ,
      STEP_X_Y,
      STEP_BETA,
      STEP_DT_DX,
      STEP_DT_DY,
      STEP_DT_DZ,
      STEP_DRAIN
   } step_type;

   typedef struct packed {
      logic [30:0]        sigma;
      logic [30:0]        rho;
      logic [30:0]        beta;
      logic [30:0]        dt;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
   } coef_type;

   typedef struct packed {
      logic     load;
      logic     prep;
      logic     run;
      step_type step;
      logic     commit;
   } dp_cmd_type;

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? MIN32 : MAX32;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      return sat32(s);
   endfunction

   function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} - {b[31], b};
      return sat32(s);
   endfunction

endpackage

>>> src/lei_csr.sv
// Configuration register file behind the APB-style port.
module lei_csr #(
   parameter int FRAC_BITS = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lei_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [lei_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [lei_pkg::CSR_DATA_W-1:0]   prdata,
   output lei_pkg::coef_type                coef
);
   import lei_pkg::*;

   localparam logic [63:0] ONE       = 64'd1 << FRAC_BITS;
   localparam logic [63:0] SIGMA_RAW = ONE * 64'd10;
   localparam logic [63:0] RHO_RAW   = ONE * 64'd28;
   localparam logic [63:0] BETA_RAW  = (ONE * 64'd16 + 64'd3) / 64'd6;
   localparam logic [63:0] DT_RAW    = (ONE + 64'd50) / 64'd100;
   localparam logic [63:0] LIM31     = 64'h7FFF_FFFF;
   localparam logic [30:0] SIGMA_RST = (SIGMA_RAW > LIM31) ? '1 : SIGMA_RAW[30:0];
   localparam logic [30:0] RHO_RST   = (RHO_RAW > LIM31) ? '1 : RHO_RAW[30:0];
   localparam logic [30:0] BETA_RST  = (BETA_RAW > LIM31) ? '1 : BETA_RAW[30:0];
   localparam logic [30:0] DT_RST    = (DT_RAW > LIM31) ? '1 : DT_RAW[30:0];
   localparam logic [31:0] START_RST = ONE[31:0];

   coef_type   coef_ff;
   coef_type   coef_in;
   logic       wr_en;
   logic [2:0] idx;

   assign wr_en = psel & penable & pwrite;
   assign idx   = paddr[4:2];

   always_comb begin
      coef_in = coef_ff;
      if (wr_en) begin
         case (idx)
            REG_SIGMA:   coef_in.sigma   = pwdata[30:0];
            REG_RHO:     coef_in.rho     = pwdata[30:0];
            REG_BETA:    coef_in.beta    = pwdata[30:0];
            REG_DT:      coef_in.dt      = pwdata[30:0];
            REG_START_X: coef_in.start_x = pwdata;
            REG_START_Y: coef_in.start_y = pwdata;
            REG_START_Z: coef_in.start_z = pwdata;
            default:     coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.sigma   <= SIGMA_RST;
         coef_ff.rho     <= RHO_RST;
         coef_ff.beta    <= BETA_RST;
         coef_ff.dt      <= DT_RST;
         coef_ff.start_x <= START_RST;
         coef_ff.start_y <= START_RST;
         coef_ff.start_z <= START_RST;
      end else begin
         coef_ff <= coef_in;
      end
   end

   always_comb begin
      case (idx)
         REG_SIGMA:   prdata = {1'b0, coef_ff.sigma};
         REG_RHO:     prdata = {1'b0, coef_ff.rho};
         REG_BETA:    prdata = {1'b0, coef_ff.beta};
         REG_DT:      prdata = {1'b0, coef_ff.dt};
         REG_START_X: prdata = coef_ff.start_x;
         REG_START_Y: prdata = coef_ff.start_y;
         REG_START_Z: prdata = coef_ff.start_z;
         default:     prdata = '0;
      endcase
   end

   assign coef = coef_ff;

endmodule

>>> src/lei_dp.sv
// Datapath: point registers, shared fixed-point multiplier and result register.
module lei_dp #(
   parameter int FRAC_BITS = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  lei_pkg::coef_type   coef,
   input  lei_pkg::dp_cmd_type cmd,
   input  logic                req_restart,
   output logic signed [31:0]  rsp_pos_x_out,
   output logic signed [31:0]  rsp_pos_y_out,
   output logic signed [31:0]  rsp_pos_z_out,
   output logic signed [31:0]  rsp_deriv_x,
   output logic signed [31:0]  rsp_deriv_y,
   output logic signed [31:0]  rsp_deriv_z
);
   import lei_pkg::*;

   localparam logic [63:0]        ONE       = 64'd1 << FRAC_BITS;
   localparam logic signed [31:0] START_RST = ONE[31:0];

   logic signed [31:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [31:0] ydx_ff, rmz_ff;
   logic signed [31:0] mul_ff, mul_in;
   logic signed [31:0] dx_ff, dy_ff, dz_ff, xy_ff;
   logic signed [31:0] ux_ff, uy_ff, uz_ff;
   logic signed [31:0] out_px_ff, out_py_ff, out_pz_ff;
   logic signed [31:0] out_dx_ff, out_dy_ff, out_dz_ff;
   logic signed [31:0] op_a, op_b;
   logic signed [63:0] prod, prod_sh;
   logic [32:0]        prod_hi;

   // Operand select for the shared multiplier.
   always_comb begin
      case (cmd.step)
         STEP_SIGMA: begin
            op_a = signed'({1'b0, coef.sigma});
            op_b = ydx_ff;
         end
         STEP_X_RZ: begin
            op_a = pos_x_ff;
            op_b = rmz_ff;
         end
         STEP_X_Y: begin
            op_a = pos_x_ff;
            op_b = pos_y_ff;
         end
         STEP_BETA: begin
            op_a = signed'({1'b0, coef.beta});
            op_b = pos_z_ff;
         end
         STEP_DT_DX: begin
            op_a = signed'({1'b0, coef.dt});
            op_b = dx_ff;
         end
         STEP_DT_DY: begin
            op_a = signed'({1'b0, coef.dt});
            op_b = dy_ff;
         end
         STEP_DT_DZ: begin
            op_a = signed'({1'b0, coef.dt});
            op_b = dz_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Exact product, floor shift, saturate.
   assign prod    = 64'(op_a) * 64'(op_b);
   assign prod_sh = prod >>> FRAC_BITS;
   assign prod_hi = prod_sh[63:31];

   always_comb begin
      if ((&prod_hi) || !(|prod_hi)) begin
         mul_in = prod_sh[31:0];
      end else begin
         mul_in = prod_sh[63] ? MIN32 : MAX32;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= START_RST;
         pos_y_ff <= START_RST;
         pos_z_ff <= START_RST;
      end else if (cmd.load && req_restart) begin
         pos_x_ff <= coef.start_x;
         pos_y_ff <= coef.start_y;
         pos_z_ff <= coef.start_z;
      end else if (cmd.commit) begin
         pos_x_ff <= sat_add(pos_x_ff, ux_ff);
         pos_y_ff <= sat_add(pos_y_ff, uy_ff);
         pos_z_ff <= sat_add(pos_z_ff, uz_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         ydx_ff <= sat_sub(pos_y_ff, pos_x_ff);
         rmz_ff <= sat_sub(signed'({1'b0, coef.rho}), pos_z_ff);
      end
      if (cmd.run) begin
         mul_ff <= mul_in;
         // retire the product of the previous step
         case (cmd.step)
            STEP_X_RZ:  dx_ff <= mul_ff;
            STEP_X_Y:   dy_ff <= sat_sub(mul_ff, pos_y_ff);
            STEP_BETA:  xy_ff <= mul_ff;
            STEP_DT_DX: dz_ff <= sat_sub(xy_ff, mul_ff);
            STEP_DT_DY: ux_ff <= mul_ff;
            STEP_DT_DZ: uy_ff <= mul_ff;
            STEP_DRAIN: uz_ff <= mul_ff;
            default: ;
         endcase
      end
      if (cmd.commit) begin
         out_px_ff <= pos_x_ff;
         out_py_ff <= pos_y_ff;
         out_pz_ff <= pos_z_ff;
         out_dx_ff <= dx_ff;
         out_dy_ff <= dy_ff;
         out_dz_ff <= dz_ff;
      end
   end

   assign rsp_pos_x_out = out_px_ff;
   assign rsp_pos_y_out = out_py_ff;
   assign rsp_pos_z_out = out_pz_ff;
   assign rsp_deriv_x   = out_dx_ff;
   assign rsp_deriv_y   = out_dy_ff;
   assign rsp_deriv_z   = out_dz_ff;

endmodule

>>> src/lei_ctrl.sv
// Controller: sequences one item through the datapath and owns the result valid.
module lei_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lei_pkg::dp_cmd_type cmd
);
   import lei_pkg::*;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_SIGMA;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '{load: 1'b0, prep: 1'b0, run: 1'b0, step: step_ff, commit: 1'b0};
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            step_in  = STEP_SIGMA;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.run = 1'b1;
            if (step_ff == STEP_DRAIN) begin
               state_in = ST_FIN;
            end else begin
               step_in = step_type'(3'(step_ff + 3'd1));
            end
         end
         ST_FIN: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> src/lorenz_euler_integrator.sv
// Top level of the fixed-point Lorenz attractor generator (forward Euler).
// An accepted item passes the prep state, the multiply/retire steps and the commit state.
// A new item is taken only back in idle, after the last one has committed; seven products share one multiplier.
// A full result register only stalls the final commit cycle; the first result need not wait.
// Reset (synchronous, active high) loads the default coefficients and start point,
// sets the point to the start point and empties the result register.
module lorenz_euler_integrator #(
   parameter int FRAC_BITS = 20
) (
   input  logic                           clock,
   input  logic                           reset,
   // input channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_restart,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [31:0]             rsp_pos_x_out,
   output logic signed [31:0]             rsp_pos_y_out,
   output logic signed [31:0]             rsp_pos_z_out,
   output logic signed [31:0]             rsp_deriv_x,
   output logic signed [31:0]             rsp_deriv_y,
   output logic signed [31:0]             rsp_deriv_z,
   // configuration port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [lei_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lei_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lei_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import lei_pkg::*;

   coef_type   coef;
   dp_cmd_type cmd;

   // Zero-wait-state register access.
   assign csr_pready = 1'b1;

   // Coefficients and start point; the user must write them only while idle; the block does not enforce it.
   lei_csr #(
      .FRAC_BITS(FRAC_BITS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .coef    (coef)
   );

   // Sequencer: idle, difference prep, eight multiply/retire steps, commit.
   lei_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Point state, derivative pipeline and the result register.
   // Commit copies the pre-update point and derivative out, then advances the point.
   lei_dp #(
      .FRAC_BITS(FRAC_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .coef          (coef),
      .cmd           (cmd),
      .req_restart   (req_restart),
      .rsp_pos_x_out (rsp_pos_x_out),
      .rsp_pos_y_out (rsp_pos_y_out),
      .rsp_pos_z_out (rsp_pos_z_out),
      .rsp_deriv_x   (rsp_deriv_x),
      .rsp_deriv_y   (rsp_deriv_y),
      .rsp_deriv_z   (rsp_deriv_z)
   );

endmodule

>>> src/lei_check.sv
// Port-level assertions for the Lorenz Euler integrator, bound to the top level.
module lei_check (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_pos_x_out,
   input logic signed [31:0] rsp_deriv_z
);

   // One item at a time: ready drops right after an accept.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while an item is in flight");

   // A result never shows up in the cycle after an accept.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // Hold a stalled result.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_pos_x_out) && $stable(rsp_deriv_z)))
      else $error("stalled result changed");

endmodule

bind lorenz_euler_integrator lei_check u_lei_check (.*);
